// ----- design/sitda_pkg.sv -----
// Shared constants, types and the double-dabble step for the integer-to-decimal core.
`default_nettype none

package sitda_pkg;

    localparam int C_VAL_W    = 32;
    localparam int C_DIGITS   = 10;
    localparam int C_BCD_W    = 4 * C_DIGITS;
    localparam int C_IDX_W    = 4;
    localparam int C_CHAR_W   = 6;
    localparam int C_STEP_BITS = 8;
    localparam int C_DD_STG   = C_VAL_W / C_STEP_BITS;
    localparam int C_NSTG     = C_DD_STG + 2;

    localparam logic [C_CHAR_W-1:0] C_CODE_MINUS = 6'd45;
    localparam logic [C_CHAR_W-1:0] C_CODE_ZERO  = 6'd48;

    typedef logic [C_BCD_W-1:0] t_bcd;

    // One converted value on its way to the character serializer
    typedef struct packed {
        logic               neg;
        t_bcd               bcd;
        logic [C_IDX_W-1:0] ndm1;
    } t_bcd_item;

    // Add three to every digit of five or more, then shift one bit in
    function automatic t_bcd dd_step(input t_bcd b, input logic bin);
        t_bcd       r;
        logic [3:0] d;
        for (int i = 0; i < C_DIGITS; i++) begin
            d = b[4*i +: 4];
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            r[4*i +: 4] = d;
        end
        return {r[C_BCD_W-2:0], bin};
    endfunction

    // Consume the top bits of the magnitude, one dabble step per bit
    function automatic t_bcd dd_chunk(input t_bcd b, input logic [C_VAL_W-1:0] m);
        t_bcd r;
        r = b;
        for (int i = 0; i < C_STEP_BITS; i++) begin
            r = dd_step(r, m[C_VAL_W-1-i]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sitda_if.sv -----
// Valid/ready channel interfaces for the integer input and the character output.
`default_nettype none

interface sitda_in_if import sitda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [C_VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [C_CHAR_W-1:0] char_code;
    logic                last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ----- design/sitda_bcd_pipe.sv -----
// Pipelined sign split, binary-to-BCD conversion and digit count.
`default_nettype none

module sitda_bcd_pipe import sitda_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [C_VAL_W-1:0] i_value,
    output logic                    o_rdy,
    output logic                    o_vld,
    output t_bcd_item               o_item,
    input  wire logic               i_rdy
);

    logic [C_NSTG-1:0]  r_vld;
    logic [C_NSTG:0]    adv;

    logic               r_s0_neg;
    logic [C_VAL_W-1:0] r_s0_mag;

    logic               r_dd_neg [C_DD_STG];
    logic [C_VAL_W-1:0] r_dd_mag [C_DD_STG];
    t_bcd               r_dd_bcd [C_DD_STG];
    t_bcd               n_dd_bcd [C_DD_STG];

    t_bcd_item          r_out;
    logic [C_IDX_W-1:0] n_ndm1;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        adv[C_NSTG] = i_rdy;
        for (int k = C_NSTG - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[C_NSTG-1];
    assign o_item = r_out;

    // Move valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < C_NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Split sign and form the magnitude
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_neg <= i_value[C_VAL_W-1];
            r_s0_mag <= i_value[C_VAL_W-1] ? (~i_value + 1'b1) : i_value;
        end
    end

    // Run a slice of the double dabble in each stage
    always_comb begin
        n_dd_bcd[0] = dd_chunk('0, r_s0_mag);
        for (int j = 1; j < C_DD_STG; j++) begin
            n_dd_bcd[j] = dd_chunk(r_dd_bcd[j-1], r_dd_mag[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_dd_neg[0] <= r_s0_neg;
            r_dd_mag[0] <= r_s0_mag << C_STEP_BITS;
            r_dd_bcd[0] <= n_dd_bcd[0];
        end
        for (int j = 1; j < C_DD_STG; j++) begin
            if (adv[j+1]) begin
                r_dd_neg[j] <= r_dd_neg[j-1];
                r_dd_mag[j] <= r_dd_mag[j-1] << C_STEP_BITS;
                r_dd_bcd[j] <= n_dd_bcd[j];
            end
        end
    end

    // Find the highest nonzero digit; zero keeps a single digit
    always_comb begin
        n_ndm1 = '0;
        for (int i = 1; i < C_DIGITS; i++) begin
            if (r_dd_bcd[C_DD_STG-1][4*i +: 4] != 4'd0) begin
                n_ndm1 = C_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[C_NSTG-1]) begin
            r_out.neg  <= r_dd_neg[C_DD_STG-1];
            r_out.bcd  <= r_dd_bcd[C_DD_STG-1];
            r_out.ndm1 <= n_ndm1;
        end
    end

endmodule

`default_nettype wire

// ----- design/signed_int_to_decimal_ascii_core.sv -----
// Top level: signed 32-bit integer in, decimal ASCII characters out.
//
//   Channel   Dir   Payload              Meaning
//   i_in      in    value[31:0] signed   integer to print
//   o_out     out   char_code[5:0],last  one character; last marks end of run
//
// A request passes six pipeline stages (sign split, four double-dabble
// slices of eight bits each, digit count) and reaches the serializer.
// The serializer sends one character per cycle while o_out is ready, 1 to 11
// per value, and loads the next value in the cycle it sends the last one.
// Reset clears the valid bits and the
// serializer; a stall on o_out holds every stage without loss.
`default_nettype none

module signed_int_to_decimal_ascii_core import sitda_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);

    logic               pipe_vld;
    logic               load;
    t_bcd_item          pipe_item;

    logic               r_bsy;
    logic               r_neg;
    logic [C_IDX_W-1:0] r_idx;
    t_bcd               r_dig;

    logic               r_ovld;
    logic [C_CHAR_W-1:0] r_char;
    logic               r_last;

    logic               out_mv;
    logic               emit;
    logic               fin;
    logic [3:0]         cur_dig;

    sitda_bcd_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .i_value (i_in.value),
        .o_rdy   (i_in.ready),
        .o_vld   (pipe_vld),
        .o_item  (pipe_item),
        .i_rdy   (load)
    );

    // Send a character when the output slot frees; load on the final one
    assign out_mv  = !r_ovld || o_out.ready;
    assign emit    = r_bsy && out_mv;
    assign fin     = emit && !r_neg && (r_idx == '0);
    assign load    = !r_bsy || fin;
    assign cur_dig = r_dig[{r_idx, 2'b00} +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsy  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (out_mv) begin
                r_ovld <= r_bsy;
            end
            if (load) begin
                r_bsy <= pipe_vld;
            end
        end
    end

    // Hold the digits and walk down from the leading one
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_neg) begin
                r_char <= C_CODE_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= C_CODE_ZERO + {2'b00, cur_dig};
                r_last <= (r_idx == '0);
            end
        end
        if (load && pipe_vld) begin
            r_dig <= pipe_item.bcd;
            r_neg <= pipe_item.neg;
            r_idx <= pipe_item.ndm1;
        end else if (emit) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    assign o_out.valid     = r_ovld;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the integer-to-decimal core: self-checking, random stalls on both channels.
`timescale 1ns / 1ps
`default_nettype none

module tb import sitda_pkg::*; ();

    localparam int RADIX      = 10;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int TAIL_CYCLES = 40;

    // One expected character of a decimal run
    typedef struct packed {
        logic [C_CHAR_W-1:0] code;
        logic                last;
    } t_char;

    logic i_clk;
    logic i_rst_n;

    sitda_in_if  u_in ();
    sitda_out_if u_out ();

    t_char expected_text_q[$];
    int    error_count    = 0;
    int    char_count     = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;

    signed_int_to_decimal_ascii_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Append the decimal text of one request to the expected characters
    function automatic void predict_text(input logic [C_VAL_W-1:0] raw);
        logic [C_VAL_W-1:0] mag;
        logic [3:0]         dig [C_DIGITS];
        int                 n;
        t_char              c;
        mag = raw[C_VAL_W-1] ? (~raw + 1'b1) : raw;
        n = 0;
        do begin
            dig[n] = 4'(mag % RADIX);
            n++;
            mag = mag / RADIX;
        end while (mag != 0 && n < C_DIGITS);
        if (raw[C_VAL_W-1]) begin
            c.code = C_CODE_MINUS;
            c.last = 1'b0;
            expected_text_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.code = C_CODE_ZERO + C_CHAR_W'(dig[k]);
            c.last = (k == 0);
            expected_text_q.push_back(c);
        end
    endfunction

    // Mix of full-width words and values of a random digit count and sign
    function automatic logic [C_VAL_W-1:0] random_value();
        int unsigned        ndig;
        longint unsigned    top;
        logic [C_VAL_W-1:0] v;
        if ($urandom_range(0, 1) == 1) begin
            return $urandom();
        end
        ndig = $urandom_range(1, C_DIGITS);
        top = 1;
        repeat (ndig) top = top * RADIX;
        top = top - 1;
        if (top > 64'h7FFF_FFFF) begin
            top = 64'h7FFF_FFFF;
        end
        v = $urandom_range(0, 32'(top));
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    // Offer one request, idling first at the current rate, and record its text
    task automatic send_value(input logic [C_VAL_W-1:0] v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            u_in.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        u_in.valid <= 1'b1;
        u_in.value <= v;
        do @(posedge i_clk); while (!u_in.ready);
        predict_text(v);
    endtask

    // Drop valid and hold until every expected character has come out
    task automatic wait_for_text();
        u_in.valid <= 1'b0;
        while (expected_text_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Check each character against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin : check_chars
        t_char want;
        if (!i_rst_n) begin
            u_out.ready <= 1'b0;
        end else begin
            if (u_out.valid && u_out.ready) begin
                char_count++;
                if (expected_text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char_code %0d last %0b",
                                              u_out.char_code, u_out.last));
                end else begin
                    want = expected_text_q.pop_front();
                    if (u_out.char_code !== want.code) begin
                        report_mismatch($sformatf("char %0d: char_code %0d, want %0d",
                                                  char_count, u_out.char_code, want.code));
                    end
                    if (u_out.last !== want.last) begin
                        report_mismatch($sformatf("char %0d: last %0b, want %0b",
                                                  char_count, u_out.last, want.last));
                    end
                end
            end
            u_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Zero, one, minus one, both ends of the range, the minimum plus one and minus nine
    task automatic test_extremes();
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0001);
        send_value(-32'sd9);
    endtask

    // Every run length: powers of ten and the value just below, mixed signs
    task automatic test_digit_counts();
        logic [C_VAL_W-1:0] p;
        p = 1;
        for (int k = 1; k < C_DIGITS; k++) begin
            p = p * RADIX;
            send_value((k % 2 == 1) ? p : -p);
            send_value((k % 2 == 1) ? -(p - 1) : (p - 1));
        end
    endtask

    // Stop sending mid-stream until the output is empty, then resume
    task automatic test_drain_pause();
        repeat (5) send_value(random_value());
        wait_for_text();
        repeat (5) send_value(random_value());
    endtask

    // Random requests under one idling mix
    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_value(random_value());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        u_in.valid  = 1'b0;
        u_in.value  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_digit_counts();
        test_drain_pause();
        test_random_phase(125, 0, 0);
        test_random_phase(125, 84, 0);
        test_random_phase(125, 0, 84);
        test_random_phase(125, 38, 38);

        // Flush the tail with the receiver always ready
        recv_stall_pct = 0;
        wait_for_text();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_text_q.size() != 0) begin
            report_mismatch($sformatf("%0d characters never came out",
                                      expected_text_q.size()));
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout waiting on the core");
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- signed_int_to_decimal_ascii_core.f -----
design/sitda_pkg.sv
design/sitda_if.sv
design/sitda_bcd_pipe.sv
design/signed_int_to_decimal_ascii_core.sv
tb/tb.sv
